// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer: shared package
// Character codes, register indexes, field widths and the command word that
// the front end passes to the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Field widths of the request and response.
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 4;

   // Wide enough for a cell address at the largest grid the design supports.
   localparam int MAX_ADDR_W = 12;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_BS          = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB         = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF          = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR          = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE       = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LAST  = 8'h7F;

   // Request operations.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Register indexes.
   localparam logic CSR_BACKGROUND = 1'b0;
   localparam logic CSR_FOREGROUND = 1'b1;

   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'h0;
   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'hF;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_PUT,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      scroll;
      logic                      read_hit;
      logic [MAX_ADDR_W-1:0]     addr;
      logic [2*COLOR_W-1:0]      attr;
      logic [CHAR_W-1:0]         char_code;
      logic [POS_W-1:0]          cursor_position;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_COPY,
      BK_DRAIN,
      BK_FILL,
      BK_HOLD
   } back_state_type;

endpackage

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console character writer: front end
// Accepts requests, keeps the cursor and colour registers, decodes each byte
// and pushes one command per request into the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_index,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_wdata,
   input  logic                          q_full,
   input  logic                          clear_busy,
   output logic                          q_push,
   output tcw_pkg::cmd_type              q_cmd
);

   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW         = $clog2(COLUMNS + 8);
   localparam int RW         = $clog2(ROWS + 1);
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW         = tcw_pkg::MAX_ADDR_W;

   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [tcw_pkg::COLOR_W-1:0] bg_ff, bg_in;
   logic [tcw_pkg::COLOR_W-1:0] fg_ff, fg_in;

   logic [CW-1:0] col_step, col_fin;
   logic [RW-1:0] row_step, row_fin;
   logic          printable;
   logic          scroll;
   logic [AW-1:0] cur_pos, next_pos;
   logic          accept;

   assign req_tready = !q_full && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   assign printable = (req_char >= tcw_pkg::CHAR_SPACE) &&
                      (req_char <= tcw_pkg::CHAR_PRINT_LAST);

   // Cursor update for one byte: control move, then line wrap, then scroll.
   always_comb begin
      col_step = CW'(col_ff);
      row_step = RW'(row_ff);
      case (req_char)
         tcw_pkg::CHAR_BS: begin
            if (col_ff != '0) col_step = CW'(col_ff) - CW'(1);
         end
         tcw_pkg::CHAR_TAB: begin
            col_step = (CW'(col_ff) + CW'(8)) & ~CW'(7);
         end
         tcw_pkg::CHAR_CR: begin
            col_step = '0;
         end
         tcw_pkg::CHAR_LF: begin
            col_step = '0;
            row_step = RW'(row_ff) + RW'(1);
         end
         default: begin
            if (printable) col_step = CW'(col_ff) + CW'(1);
         end
      endcase

      col_fin = col_step;
      row_fin = row_step;
      if (col_step >= CW'(COLUMNS)) begin
         col_fin = '0;
         row_fin = row_step + RW'(1);
      end

      scroll = 1'b0;
      if (row_fin >= RW'(ROWS)) begin
         row_fin = RW'(ROWS - 1);
         scroll  = 1'b1;
      end
   end

   assign cur_pos  = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign next_pos = AW'(row_fin) * AW'(COLUMNS) + AW'(col_fin);

   always_comb begin
      q_cmd.attr      = {bg_ff, fg_ff};
      q_cmd.char_code = req_char;
      q_cmd.read_hit  = (AW'(req_index) < AW'(CELL_COUNT));
      if (req_op == tcw_pkg::OP_READ) begin
         q_cmd.kind            = tcw_pkg::CMD_READ;
         q_cmd.scroll          = 1'b0;
         q_cmd.addr            = AW'(req_index);
         q_cmd.cursor_position = cur_pos[tcw_pkg::POS_W-1:0];
      end else begin
         q_cmd.kind            = printable ? tcw_pkg::CMD_PUT : tcw_pkg::CMD_NONE;
         q_cmd.scroll          = scroll;
         q_cmd.addr            = cur_pos;
         q_cmd.cursor_position = next_pos[tcw_pkg::POS_W-1:0];
      end
   end

   assign q_push = accept;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && req_op == tcw_pkg::OP_WRITE) begin
         col_in = col_fin[COL_W-1:0];
         row_in = row_fin[ROW_W-1:0];
      end
      bg_in = bg_ff;
      fg_in = fg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tcw_pkg::CSR_BACKGROUND: bg_in = csr_wdata;
            tcw_pkg::CSR_FOREGROUND: fg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         bg_ff  <= tcw_pkg::BACKGROUND_RESET;
         fg_ff  <= tcw_pkg::FOREGROUND_RESET;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         bg_ff  <= bg_in;
         fg_ff  <= fg_in;
      end
   end

endmodule

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console character writer: command queue
// Short in-order queue that decouples request decoding from cell memory work.
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output tcw_pkg::cmd_type head
);

   localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tcw_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console character writer: back end
// Owns the cell memory. Clears it after reset, executes queued commands
// (store, read, scroll copy and blank fill) and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  tcw_pkg::cmd_type             q_head,
   output logic                         q_pop,
   output logic                         clear_busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tcw_pkg::POS_W-1:0]    rsp_position,
   output logic [tcw_pkg::CELL_W-1:0]   rsp_read_data,
   output logic                         rsp_scrolled
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);

   tcw_pkg::back_state_type state_ff, state_in;

   logic [tcw_pkg::CELL_W-1:0] cells_ff [CELL_COUNT];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0]          cnt_ff, cnt_in;
   logic                       pend_ff, pend_in;
   logic [ADDR_W-1:0]          pend_addr_ff, pend_addr_in;
   tcw_pkg::cmd_type           cmd_ff, cmd_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]  rsp_pos_ff;
   logic [tcw_pkg::CELL_W-1:0] rsp_data_ff;
   logic                       rsp_scr_ff;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [tcw_pkg::CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       load;
   logic [tcw_pkg::POS_W-1:0]  load_pos;
   logic [tcw_pkg::CELL_W-1:0] load_data;
   logic                       load_scr;
   logic                       out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign clear_busy = (state_ff == tcw_pkg::BK_CLEAR);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::BK_CLEAR: begin
            if (cnt_ff == LAST_ADDR) state_in = tcw_pkg::BK_IDLE;
         end
         tcw_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_head.scroll) state_in = tcw_pkg::BK_COPY;
               else if (q_head.kind == tcw_pkg::CMD_READ) state_in = tcw_pkg::BK_HOLD;
               else if (!out_free) state_in = tcw_pkg::BK_HOLD;
            end
         end
         tcw_pkg::BK_COPY: begin
            if (cnt_ff == LAST_ADDR) state_in = tcw_pkg::BK_DRAIN;
         end
         tcw_pkg::BK_DRAIN: begin
            state_in = tcw_pkg::BK_FILL;
         end
         tcw_pkg::BK_FILL: begin
            if (cnt_ff == LAST_ADDR) state_in = tcw_pkg::BK_HOLD;
         end
         tcw_pkg::BK_HOLD: begin
            if (out_free) state_in = tcw_pkg::BK_IDLE;
         end
         default: state_in = tcw_pkg::BK_IDLE;
      endcase
   end

   // Memory port control and datapath. During a scroll, each cycle reads
   // one cell of the source row and writes the cell read in the previous
   // cycle one row higher.
   always_comb begin
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = '0;
      rd_addr      = cmd_ff.addr[ADDR_W-1:0];
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      pend_in      = 1'b0;
      pend_addr_in = cnt_ff - ADDR_W'(COLUMNS);
      load         = 1'b0;
      load_pos     = cmd_ff.cursor_position;
      load_data    = (cmd_ff.kind == tcw_pkg::CMD_READ && cmd_ff.read_hit) ? rd_data_ff : '0;
      load_scr     = cmd_ff.scroll;
      case (state_ff)
         tcw_pkg::BK_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + ADDR_W'(1);
         end
         tcw_pkg::BK_IDLE: begin
            rd_addr = q_head.addr[ADDR_W-1:0];
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               if (q_head.kind == tcw_pkg::CMD_PUT) begin
                  wr_en   = 1'b1;
                  wr_addr = q_head.addr[ADDR_W-1:0];
                  wr_data = {q_head.attr, q_head.char_code};
               end
               if (q_head.scroll) begin
                  cnt_in = ADDR_W'(COLUMNS);
               end else if (q_head.kind != tcw_pkg::CMD_READ && out_free) begin
                  load      = 1'b1;
                  load_pos  = q_head.cursor_position;
                  load_data = '0;
                  load_scr  = 1'b0;
               end
            end
         end
         tcw_pkg::BK_COPY: begin
            rd_addr = cnt_ff;
            pend_in = 1'b1;
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data_ff;
            cnt_in  = cnt_ff + ADDR_W'(1);
         end
         tcw_pkg::BK_DRAIN: begin
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff;
            wr_data = rd_data_ff;
            cnt_in  = FILL_FIRST;
         end
         tcw_pkg::BK_FILL: begin
            wr_en   = 1'b1;
            wr_data = {cmd_ff.attr, tcw_pkg::CHAR_SPACE};
            cnt_in  = cnt_ff + ADDR_W'(1);
         end
         tcw_pkg::BK_HOLD: begin
            load = out_free;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::BK_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      cmd_ff       <= cmd_in;
      if (load) begin
         rsp_pos_ff  <= load_pos;
         rsp_data_ff <= load_data;
         rsp_scr_ff  <= load_scr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) cells_ff[wr_addr] <= wr_data;
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_scrolled  = rsp_scr_ff;

endmodule

// File: rtl/text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// Text console character writer core
// Character stream in, cursor position and cell reads out. The front end
// decodes bytes and moves the cursor; the back end owns the cell memory.
// ----------------------------------------------------------------------------
// Path: a request passes the command queue and the response register; a cell read
//   also passes the memory read register, with the back end in its HOLD state.
// Throughput: one byte per cycle while no scroll occurs and each response is taken;
//   a read passes the IDLE and HOLD states of the back end; a scroll copies the grid
//   one cell per cycle through the memory's read and write ports.
// Reset: the cursor goes home and the colours to 0/15; the memory is then
//   cleared one cell per cycle while req_tready is low.
module text_console_char_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // char_code[7:0], cell_index[18:8]
   input  logic                        req_tuser,  // op
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,  // cursor_position[10:0],
                                                   // read_data[26:11], scrolled[27]
   // Register writes.
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0] csr_wdata
);

   localparam int CELL_COUNT = ROWS * COLUMNS;

   logic                          q_push, q_pop, q_full, q_empty;
   tcw_pkg::cmd_type              q_cmd, q_head;
   logic                          clear_busy;
   logic [tcw_pkg::POS_W-1:0]     rsp_position;
   logic [tcw_pkg::CELL_W-1:0]    rsp_read_data;
   logic                          rsp_scrolled;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_index  (req_tdata[18:8]),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .clear_busy    (clear_busy),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_position  (rsp_position),
      .rsp_read_data (rsp_read_data),
      .rsp_scrolled  (rsp_scrolled)
   );

   assign rsp_tdata = {4'b0000, rsp_scrolled, rsp_read_data, rsp_position};

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready)
      else $error("request accepted during the memory clear");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[10:0]) < 32'(CELL_COUNT)))
      else $error("cursor position outside the grid");

   a_scroll_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[27]) |-> (rsp_tdata[26:11] == 16'h0000))
      else $error("scroll response carries read data");

endmodule

// File: tb/sv/tb_text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// Text console character writer core: testbench
// Streams byte writes and cell reads into the console core and checks every
// response against a cycle-free model of the 80x25 grid and its cursor. The
// model covers cursor motion, line wrap, scroll and the attribute byte. The
// colours change between traffic phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLUMNS  = 80;
   localparam int GRID_ROWS     = 25;
   localparam int GRID_CELLS    = GRID_COLUMNS * GRID_ROWS;
   localparam int INDEX_SPAN    = 1 << tcw_pkg::INDEX_W;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int PHASES        = 5;
   localparam int MAX_GAP       = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 2 * GRID_CELLS + 16;
   localparam int END_CYCLES    = 16;
   localparam int ITEM_CYCLES   = MAX_GAP + 64 + 4;

   typedef logic [tcw_pkg::CHAR_W-1:0]  code_type;
   typedef logic [tcw_pkg::INDEX_W-1:0] index_type;
   typedef logic [tcw_pkg::COLOR_W-1:0] colour_type;
   typedef logic [tcw_pkg::POS_W-1:0]   pos_type;

   typedef struct packed {
      logic                        scrolled;
      logic [tcw_pkg::CELL_W-1:0]  read_data;
      logic [tcw_pkg::POS_W-1:0]   cursor_position;
   } screen_result_type;

   class console_scoreboard;
      logic [tcw_pkg::CELL_W-1:0]  cells [GRID_CELLS];
      int                          col;
      int                          row;
      logic [tcw_pkg::COLOR_W-1:0] background;
      logic [tcw_pkg::COLOR_W-1:0] foreground;
      screen_result_type           expected_q[$];
      int                          errors;
      int                          accepted;
      int                          checked;
      int                          reads;
      int                          scrolls;

      function new();
         foreach (cells[i]) cells[i] = '0;
         col        = 0;
         row        = 0;
         background = tcw_pkg::BACKGROUND_RESET;
         foreground = tcw_pkg::FOREGROUND_RESET;
         errors     = 0;
         accepted   = 0;
         checked    = 0;
         reads      = 0;
         scrolls    = 0;
      endfunction

      function void set_colour(input logic index,
                               input logic [tcw_pkg::COLOR_W-1:0] value);
         if (index == tcw_pkg::CSR_BACKGROUND)
            background = value;
         else
            foreground = value;
      endfunction

      function int cursor();
         return row * GRID_COLUMNS + col;
      endfunction

      function void note_request(input logic op, input logic [tcw_pkg::CHAR_W-1:0] code,
                                 input logic [tcw_pkg::INDEX_W-1:0] index);
         screen_result_type           r;
         logic [tcw_pkg::CELL_W-1:0]  attr;
         int                          i;
         attr = {background, foreground, 8'h00};
         r = '0;
         accepted++;
         if (op == tcw_pkg::OP_READ) begin
            reads++;
            if (index < GRID_CELLS)
               r.read_data = cells[index];
         end else begin
            case (code)
               tcw_pkg::CHAR_BS: begin
                  if (col != 0)
                     col--;
               end
               tcw_pkg::CHAR_TAB: col = (col + 8) & ~7;
               tcw_pkg::CHAR_CR: col = 0;
               tcw_pkg::CHAR_LF: begin
                  col = 0;
                  row++;
               end
               default: begin
                  if (code >= tcw_pkg::CHAR_SPACE && code <= tcw_pkg::CHAR_PRINT_LAST) begin
                     cells[row * GRID_COLUMNS + col] = attr | {8'h00, code};
                     col++;
                  end
               end
            endcase
            if (col >= GRID_COLUMNS) begin
               col = 0;
               row++;
            end
            // Scrolling drops the top row and blanks the bottom one in the
            // colours that are current at the time of the request.
            if (row >= GRID_ROWS) begin
               for (i = 0; i < (GRID_ROWS - 1) * GRID_COLUMNS; i++)
                  cells[i] = cells[i + GRID_COLUMNS];
               for (i = (GRID_ROWS - 1) * GRID_COLUMNS; i < GRID_CELLS; i++)
                  cells[i] = attr | {8'h00, tcw_pkg::CHAR_SPACE};
               row = GRID_ROWS - 1;
               r.scrolled = 1'b1;
               scrolls++;
            end
         end
         r.cursor_position = pos_type'(row * GRID_COLUMNS + col);
         expected_q.push_back(r);
      endfunction

      function void check_response(input logic [31:0] word);
         screen_result_type want;
         screen_result_type got;
         got = word[27:0];
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response %h with no request outstanding", $time, word);
            return;
         end
         want = expected_q.pop_front();
         if (got.cursor_position !== want.cursor_position) begin
            errors++;
            $display("%0t: cursor_position expected %0d, actual %0d", $time,
                     want.cursor_position, got.cursor_position);
         end
         if (got.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data expected %h, actual %h", $time,
                     want.read_data, got.read_data);
         end
         if (got.scrolled !== want.scrolled) begin
            errors++;
            $display("%0t: scrolled expected %b, actual %b", $time,
                     want.scrolled, got.scrolled);
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [23:0]                 req_tdata = '0;   // char_code[7:0], cell_index[18:8]
   logic                        req_tuser = 1'b0; // op
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [31:0]                 rsp_tdata;        // cursor_position[10:0], read_data[26:11],
                                                  // scrolled[27]
   logic                        csr_wr_en = 1'b0;
   logic                        csr_index = tcw_pkg::CSR_BACKGROUND;
   logic [tcw_pkg::COLOR_W-1:0] csr_wdata = '0;

   console_scoreboard   sb = new;
   longint              cycle_count = 0;
   int                  burst_left = 0;
   int                  colour_writes = 0;

   text_console_char_writer_core #(
      .COLUMNS (GRID_COLUMNS),
      .ROWS    (GRID_ROWS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // The limit grows with the work accepted so far: the clearing pass, the
   // phase pauses, every request at its slowest and every scroll's grid copy.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4 * (longint'(GRID_CELLS) + PHASES * (SETTLE_CYCLES + 8)
                             + 3 * HOLD_CYCLES + END_CYCLES + 1000
                             + longint'(sb.accepted) * ITEM_CYCLES
                             + longint'(sb.scrolls) * (GRID_CELLS + 8))) begin
         $display("tb_text_console_char_writer_core: done, errors");
         $finish;
      end
   end

   // Response side: stretches of steady, random, patterned and sparse ready,
   // with a long hold-off now and then so that the core backs up.
   initial begin
      int style;
      int stretch;
      int step;
      int next_hold;
      step = 0;
      next_hold = 150;
      forever begin
         if (sb.checked >= next_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_hold += 700;
         end
         style = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         repeat (stretch) begin
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (step % 5 != 4);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            step++;
            @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic op, input logic [tcw_pkg::CHAR_W-1:0] code,
                               input logic [tcw_pkg::INDEX_W-1:0] index);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, index, code};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, code, index);
   endtask

   task automatic write_colour(input logic index,
                               input logic [tcw_pkg::COLOR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_colour(index, value);
      colour_writes++;
   endtask

   task automatic run_traffic(input int quota);
      int target;
      int len;
      int sel;
      int near;
      int offset;
      target = sb.accepted + quota;
      while (sb.accepted < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            // A line of text with the odd backspace or tab, mostly short,
            // sometimes long enough to wrap.
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130)
                                              : $urandom_range(0, 40);
            repeat (len) begin
               sel = $urandom_range(0, 31);
               if (sel == 0)
                  send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BS,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
               else if (sel == 1)
                  send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_TAB,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
               else
                  send_request(tcw_pkg::OP_WRITE,
                               code_type'($urandom_range(tcw_pkg::CHAR_SPACE,
                                                         tcw_pkg::CHAR_PRINT_LAST)),
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
            end
            case ($urandom_range(0, 3))
               0: begin
                  send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_CR,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
                  send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LF,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
               end
               1: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LF,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
               2: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_CR,
                               index_type'($urandom_range(0, INDEX_SPAN - 1)));
               default: ;
            endcase
         end else if (sel < 75) begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 3))
                  0: begin
                     offset = $urandom_range(0, 160);
                     near = sb.cursor() - offset;
                     if (near < 0)
                        near = 0;
                  end
                  1: near = $urandom_range((GRID_ROWS - 1) * GRID_COLUMNS, GRID_CELLS - 1);
                  2: near = $urandom_range(0, INDEX_SPAN - 1);
                  default: near = $urandom_range(0, GRID_CELLS - 1);
               endcase
               send_request(tcw_pkg::OP_READ, code_type'($urandom_range(0, 255)),
                            index_type'(near));
            end
         end else if (sel < 85) begin
            send_request(1'($urandom_range(0, 1)), code_type'($urandom_range(0, 255)),
                         index_type'($urandom_range(0, INDEX_SPAN - 1)));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 4))
                  0: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BS,
                                  index_type'($urandom_range(0, INDEX_SPAN - 1)));
                  1: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_TAB,
                                  index_type'($urandom_range(0, INDEX_SPAN - 1)));
                  2: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_CR,
                                  index_type'($urandom_range(0, INDEX_SPAN - 1)));
                  3: send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LF,
                                  index_type'($urandom_range(0, INDEX_SPAN - 1)));
                  default: send_request(tcw_pkg::OP_WRITE,
                                        code_type'($urandom_range(0,
                                                   tcw_pkg::CHAR_SPACE - 1)),
                                        index_type'($urandom_range(0, INDEX_SPAN - 1)));
               endcase
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [tcw_pkg::COLOR_W-1:0] back_set;
      logic [tcw_pkg::COLOR_W-1:0] fore_set;
      int                          phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The core clears its cell memory before it takes the first request.
      while (!req_tready) @(posedge clock);
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            while (sb.expected_q.size() != 0) @(posedge clock);
            repeat (SETTLE_CYCLES) @(posedge clock);
         end
         case (phase)
            0: begin back_set = 4'h0; fore_set = 4'hF; end
            1: begin back_set = 4'hF; fore_set = 4'h0; end
            2: begin back_set = 4'hF; fore_set = 4'hF; end
            3: begin back_set = 4'h0; fore_set = 4'h0; end
            default: begin
               back_set = colour_type'($urandom_range(0, 15));
               fore_set = colour_type'($urandom_range(0, 15));
            end
         endcase
         if (phase % 2 == 0) begin
            write_colour(tcw_pkg::CSR_BACKGROUND, back_set);
            write_colour(tcw_pkg::CSR_FOREGROUND, fore_set);
         end else begin
            write_colour(tcw_pkg::CSR_FOREGROUND, fore_set);
            write_colour(tcw_pkg::CSR_BACKGROUND, back_set);
         end
         csr_wr_en <= 1'b0;
         if (phase == 0) begin
            burst_left = 32;
            send_request(tcw_pkg::OP_READ, 8'h00, 11'd0);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BS, 11'd0);  // backspace at column zero
            send_request(tcw_pkg::OP_WRITE, 8'h41, 11'h7FF);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_SPACE, 11'd0);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_PRINT_LAST, 11'd0);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_BS, 11'd0);
            send_request(tcw_pkg::OP_WRITE, 8'h00, 11'd0);   // ignored control and high bytes
            send_request(tcw_pkg::OP_WRITE, 8'h1F, 11'd0);
            send_request(tcw_pkg::OP_WRITE, 8'h80, 11'd0);
            send_request(tcw_pkg::OP_WRITE, 8'hFF, 11'd0);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_CR, 11'd0);
            send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_LF, 11'd0);
            // Ten tabs from column zero: the last one wraps to the next row.
            repeat (10) send_request(tcw_pkg::OP_WRITE, tcw_pkg::CHAR_TAB, 11'd0);
            send_request(tcw_pkg::OP_READ, 8'hFF, index_type'(GRID_CELLS - 1));
            send_request(tcw_pkg::OP_READ, 8'h00, 11'h7FF);  // index past the grid
            send_request(tcw_pkg::OP_READ, 8'h00, 11'd1);
            run_traffic(180);
         end else begin
            run_traffic(300);
         end
      end
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      $display("Covered %0d requests (%0d cell reads) with %0d scrolls over %0d colour writes.",
               sb.accepted, sb.reads, sb.scrolls, colour_writes);
      $display("Checked %0d responses, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("tb_text_console_char_writer_core: done, clean");
      else
         $display("tb_text_console_char_writer_core: done, errors");
      $finish;
   end

endmodule

// File: text_console_char_writer_core.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_char_writer_core.sv
tb/sv/tb_text_console_char_writer_core.sv
